/* rtl/dvtu_pkg.sv */
// ----------------------------------------------------------------------------
// dvtu_pkg
// shared types and constants for the distance-vector table update block
// ----------------------------------------------------------------------------
package dvtu_pkg;

  localparam int NUM_NODES = 8;
  localparam int NODE_BITS = $clog2(NUM_NODES);
  localparam int COST_BITS = 16;
  localparam int PORT_BITS = 16;
  localparam int LABEL_BITS = 8;

  localparam logic [COST_BITS-1:0] COST_INF = {COST_BITS{1'b1}};

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_ADV  = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [NODE_BITS-1:0]  sender_index;
    logic [NODE_BITS-1:0]  dest_index;
    logic [COST_BITS-1:0]  adv_cost;
    logic [PORT_BITS-1:0]  adv_dest_port;
    logic [LABEL_BITS-1:0] adv_label;
    logic                  last_entry;
  } in_item_t;

  typedef struct packed {
    logic [COST_BITS-1:0] entry_cost;
    logic [NODE_BITS-1:0] entry_next_hop;
    logic                 entry_changed;
    logic                 vector_changed;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } dvtu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } dvtu_sts_t;

endpackage

/* rtl/distance_vector_table_update_top.sv */
// ----------------------------------------------------------------------------
// distance_vector_table_update_top
// distance-vector routing table with one relaxation per item
// ----------------------------------------------------------------------------
// Input beats carry either a load (writes cost and next hop of an entry) or
// one entry of a neighbour's advertised vector. An advertisement replaces the
// entry when advertised cost plus the stored cost to the sender, saturated
// at unreachable, is strictly lower, unless the destination is self_index or
// the advertised cost is unreachable. Each input beat yields one output beat
// with the entry after the update; the beat that closes a vector also
// reports whether the vector changed any entry.
// The item and its table reads are registered when it is taken; the compare,
// write and registering of the result follow once the output is not stalled.
// in_stall is high while an item is being worked; the next item is taken
// while the previous result still waits on a stalled output.
// When out_stall holds the output, a second item waits in its compare stage.
// Reset (rst, synchronous) marks all entries unreachable with next hop zero,
// clears self_index and the vector change flag. self_index is written through
// cfg_wr_en / cfg_wr_data; the user must do so while idle (not enforced).
// ----------------------------------------------------------------------------
module distance_vector_table_update_top import dvtu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [NODE_BITS-1:0] cfg_wr_data
);

  dvtu_cmd_t cmd;
  dvtu_sts_t sts;

  dvtu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dvtu_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

/* rtl/dvtu_ctrl.sv */
// ----------------------------------------------------------------------------
// dvtu_ctrl
// sequencer: accept an item, then commit its update once the output is free
// ----------------------------------------------------------------------------
module dvtu_ctrl import dvtu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  dvtu_sts_t sts,
  output dvtu_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_CALC;
        end
      end
      ST_CALC: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/dvtu_datapath.sv */
// ----------------------------------------------------------------------------
// dvtu_datapath
// routing table, saturating relaxation and output register
// ----------------------------------------------------------------------------
module dvtu_datapath import dvtu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  in_item_t             in_data,
  input  logic                 cfg_wr_en,
  input  logic [NODE_BITS-1:0] cfg_wr_data,
  input  dvtu_cmd_t            cmd,
  output dvtu_sts_t            sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  // port and label are carried with the entry but never read back,
  // so only cost and next hop are stored
  logic [COST_BITS-1:0] cost_mem [NUM_NODES];
  logic [NODE_BITS-1:0] nh_mem   [NUM_NODES];
  logic [NUM_NODES-1:0] vld;

  logic [NODE_BITS-1:0] self_index;
  logic                 any_change;

  in_item_t             item;
  logic [COST_BITS-1:0] via_cost;
  logic [COST_BITS-1:0] cur_cost;
  logic [NODE_BITS-1:0] cur_nh;

  logic [COST_BITS:0]   sum_wide;
  logic [COST_BITS-1:0] sum_sat;
  logic                 is_adv;
  logic                 hit;
  logic                 wr;
  logic [COST_BITS-1:0] new_cost;
  out_item_t            res;

  always_comb begin
    sum_wide = {1'b0, item.adv_cost} + {1'b0, via_cost};
    sum_sat  = (sum_wide >= {1'b0, COST_INF}) ? COST_INF : sum_wide[COST_BITS-1:0];
    is_adv   = (item.kind == KIND_ADV);
    hit      = is_adv && (item.dest_index != self_index) &&
               (item.adv_cost != COST_INF) && (cur_cost > sum_sat);
    wr       = !is_adv || hit;
    new_cost = is_adv ? sum_sat : item.adv_cost;

    res.entry_cost     = wr ? new_cost : cur_cost;
    res.entry_next_hop = wr ? item.sender_index : cur_nh;
    res.entry_changed  = wr;
    res.vector_changed = is_adv && item.last_entry && (any_change || hit);
  end

  assign sts.out_busy = out_valid && out_stall;

  // entries not yet written read as unreachable with next hop zero
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item     <= in_data;
      via_cost <= vld[in_data.sender_index] ? cost_mem[in_data.sender_index] : COST_INF;
      cur_cost <= vld[in_data.dest_index] ? cost_mem[in_data.dest_index] : COST_INF;
      cur_nh   <= vld[in_data.dest_index] ? nh_mem[in_data.dest_index] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr) begin
      cost_mem[item.dest_index] <= new_cost;
      nh_mem[item.dest_index]   <= item.sender_index;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      any_change <= 1'b0;
      self_index <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        self_index <= cfg_wr_data;
      end
      if (cmd.commit) begin
        if (wr) begin
          vld[item.dest_index] <= 1'b1;
        end
        if (is_adv) begin
          any_change <= item.last_entry ? 1'b0 : (any_change || hit);
        end
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
